[hdl/nrp_pkg.sv]
// package for the nernst reversal potential block: types, constants, log2 table
package nrp_pkg;

  localparam int LogTableBits = 8;
  localparam int TabSize = (1 << LogTableBits) + 1;
  localparam int RemBits = 31 - LogTableBits;
  localparam logic [16:0] KelvinOffsetQ8 = 17'd69926;
  localparam logic [27:0] KlnQ32 = 28'd256541843;
  localparam logic [28:0] ErevLimitQ8 = 29'd256000000;

  localparam logic [1:0] RegIonCharge = 2'd0;
  localparam logic [1:0] RegTemperature = 2'd1;
  localparam int CfgIdxBits = 2;
  localparam int CfgDataBits = 16;

  typedef struct packed {
    logic [31:0] conc_inside;
    logic [31:0] conc_outside;
    logic        recompute_reversal;
  } nrp_in_t;

  typedef struct packed {
    logic signed [28:0] reversal_mv;
    logic               reversal_written;
  } nrp_out_t;

  typedef logic [TabSize-1:0][16:0] log_tab_t;

  // log2(1 + i/2^bits) in q16 by repeated squaring, last entry exactly one
  function automatic logic [16:0] log_entry(input int i);
    logic [63:0] y;
    logic [16:0] r;
    begin
      r = '0;
      if (i >= TabSize - 1) begin
        r = 17'd65536;
      end else begin
        y = 64'((64'(1 << LogTableBits) + 64'(i)) << (30 - LogTableBits));
        for (int b = 15; b >= 0; b--) begin
          y = (y * y) >> 30;
          if (y >= 64'h8000_0000) begin
            r[b] = 1'b1;
            y = y >> 1;
          end
        end
      end
      return r;
    end
  endfunction

  // whole table, evaluated once at elaboration
  function automatic log_tab_t build_log_tab();
    log_tab_t t;
    begin
      for (int i = 0; i < TabSize; i++) t[i] = log_entry(i);
      return t;
    end
  endfunction

  localparam log_tab_t LogTab = build_log_tab();

endpackage

[hdl/nernst_reversal_potential.sv]
// top level: streaming nernst reversal potential, fixed point, six stage pipeline
//
// one compartment enters per clock and its result moves through each stage into the
// output register; the pipeline advances whenever the output register is empty or
// being taken, so a full stream runs at one transaction per cycle. stages:
// leading-one search and normalize, log2 table lookup with linear interpolation,
// log difference and kelvin scale product, magnitude product, rounding divide by
// |z| (a small reciprocal multiply), and sign/select into the output register. the
// configuration (ion_charge, temperature_q8) is sampled live and must only be
// written while the pipeline is empty.
module nernst_reversal_potential (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  nrp_pkg::nrp_in_t                      in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output nrp_pkg::nrp_out_t                     out_data,
  input  logic                                  cfg_we,
  input  logic [nrp_pkg::CfgIdxBits-1:0]        cfg_index,
  input  logic [nrp_pkg::CfgDataBits-1:0]       cfg_data
);

  localparam int NS = 6;

  logic signed [3:0]  ion_charge;
  logic signed [15:0] temperature_q8;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ion_charge     <= 4'sd1;
      temperature_q8 <= 16'sd1613;
    end else if (cfg_we) begin
      case (cfg_index)
        nrp_pkg::RegIonCharge:   ion_charge <= cfg_data[3:0];
        nrp_pkg::RegTemperature: temperature_q8 <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [NS-1:0] vld;
  logic advance;
  assign advance  = !vld[NS-1] || out_ready;
  assign in_ready = advance;
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (advance) vld <= {vld[NS-2:0], in_valid};
  end

  // item class: 0 normal, forced value otherwise
  typedef struct packed {
    logic        rec;
    logic        forced;
    logic [28:0] fval;
  } ctl_t;

  // ---------------- stage 1: normalize
  function automatic logic [4:0] lead(input logic [31:0] x);
    logic [4:0] p;
    begin
      p = '0;
      for (int k = 0; k < 32; k++) if (x[k]) p = 5'(k);
      return p;
    end
  endfunction

  ctl_t s1_ctl;
  logic [4:0] s1_pi, s1_po;
  logic [31:0] s1_mi, s1_mo;
  ctl_t c0;
  logic [4:0] pi0, po0;
  always_comb begin
    c0.rec = in_data.recompute_reversal;
    c0.forced = 1'b1;
    c0.fval = '0;
    if (!in_data.recompute_reversal) c0.fval = '0;
    else if (ion_charge == 4'sd0) c0.fval = '0;
    else if (in_data.conc_inside == '0) c0.fval = nrp_pkg::ErevLimitQ8;
    else if (in_data.conc_outside == '0) c0.fval = 29'(-$signed({1'b0, nrp_pkg::ErevLimitQ8}));
    else c0.forced = 1'b0;
    pi0 = lead(in_data.conc_inside);
    po0 = lead(in_data.conc_outside);
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_ctl <= c0;
      s1_pi  <= pi0;
      s1_po  <= po0;
      s1_mi  <= in_data.conc_inside << (5'd31 - pi0);
      s1_mo  <= in_data.conc_outside << (5'd31 - po0);
    end
  end

  // ---------------- stage 2: table and interpolation
  function automatic logic [16:0] tab(input logic [nrp_pkg::LogTableBits:0] i);
    return nrp_pkg::LogTab[i];
  endfunction

  function automatic logic [20:0] lg(input logic [4:0] p, input logic [31:0] m);
    logic [nrp_pkg::LogTableBits-1:0] idx;
    logic [nrp_pkg::RemBits-1:0] rem;
    logic [16:0] lo, hi;
    logic [16+nrp_pkg::RemBits:0] pr;
    begin
      idx = m[30 -: nrp_pkg::LogTableBits];
      rem = m[nrp_pkg::RemBits-1:0];
      lo = tab({1'b0, idx});
      hi = tab({1'b0, idx} + 1'b1);
      pr = (17+nrp_pkg::RemBits)'(hi - lo) * (17+nrp_pkg::RemBits)'(rem);
      return {p, 16'd0} + 21'(lo) + 21'(pr >> nrp_pkg::RemBits);
    end
  endfunction

  ctl_t s2_ctl;
  logic [20:0] s2_li, s2_lo;
  always_ff @(posedge clk) begin
    if (advance) begin
      s2_ctl <= s1_ctl;
      s2_li  <= lg(s1_pi, s1_mi);
      s2_lo  <= lg(s1_po, s1_mo);
    end
  end

  // ---------------- stage 3: difference, kelvin product
  ctl_t s3_ctl;
  logic [20:0] s3_lm;
  logic s3_neg;
  logic [44:0] s3_tprod;
  logic signed [21:0] dl;
  logic [16:0] tk;
  always_comb begin
    dl = $signed({1'b0, s2_lo}) - $signed({1'b0, s2_li});
    tk = 17'($signed(temperature_q8) + $signed({1'b0, nrp_pkg::KelvinOffsetQ8}));
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      s3_ctl   <= s2_ctl;
      s3_lm    <= 21'(dl[21] ? -dl : dl);
      s3_neg   <= dl[21] != ion_charge[3];
      s3_tprod <= 45'(tk) * 45'(nrp_pkg::KlnQ32);
    end
  end

  // ---------------- stage 4: magnitude product
  ctl_t s4_ctl;
  logic s4_neg;
  logic [41:0] s4_prod;
  logic [20:0] a;
  assign a = 21'((s3_tprod + 45'(1 << 23)) >> 24);
  always_ff @(posedge clk) begin
    if (advance) begin
      s4_ctl  <= s3_ctl;
      s4_neg  <= s3_neg;
      s4_prod <= 42'(a) * 42'(s3_lm);
    end
  end

  // ---------------- stage 5: rounding divide by |z| (1..8)
  ctl_t s5_ctl;
  logic s5_neg;
  logic [18:0] s5_q;
  logic [17:0] m;
  logic [3:0] zm;
  logic [21:0] num;
  logic [18:0] q5;
  always_comb begin
    m   = 18'((s4_prod + 42'(1 << 23)) >> 24);
    zm  = 4'(ion_charge[3] ? -ion_charge : ion_charge);
    num = 22'(m) + 22'(zm >> 1);
    case (zm)
      4'd1: q5 = 19'(num);
      4'd2: q5 = 19'(num >> 1);
      4'd4: q5 = 19'(num >> 2);
      4'd8: q5 = 19'(num >> 3);
      4'd3: q5 = 19'((45'(num) * 45'd11184811) >> 25);
      4'd5: q5 = 19'((45'(num) * 45'd6710887) >> 25);
      4'd6: q5 = 19'((45'(num) * 45'd5592406) >> 25);
      4'd7: q5 = 19'((45'(num) * 45'd4793491) >> 25);
      default: q5 = 19'(num);
    endcase
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      s5_ctl <= s4_ctl;
      s5_neg <= s4_neg;
      s5_q   <= q5;
    end
  end

  // ---------------- stage 6: sign, select, output register
  nrp_pkg::nrp_out_t res;
  always_comb begin
    res.reversal_written = s5_ctl.rec;
    if (s5_ctl.forced) res.reversal_mv = s5_ctl.fval;
    else if (s5_neg) res.reversal_mv = 29'(-$signed({10'd0, s5_q}));
    else res.reversal_mv = 29'(s5_q);
  end
  always_ff @(posedge clk) begin
    if (advance) out_data <= res;
  end

  // assertions
  a_ready: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready) else $error("ready while stalled");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_data))
    else $error("output changed under stall");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> vld[0]) else $error("accepted item lost");
endmodule

[tb/tb_nernst_reversal_potential.sv]
// testbench for the nernst reversal potential block: directed and random compartments
module tb_nernst_reversal_potential;

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_ready;
  nrp_pkg::nrp_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  nrp_pkg::nrp_out_t out_data;
  logic     cfg_we;
  logic [nrp_pkg::CfgIdxBits-1:0]  cfg_index;
  logic [nrp_pkg::CfgDataBits-1:0] cfg_data;

  nernst_reversal_potential DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // pipeline is six stages deep; drain margin after the last result
  localparam int DrainCycles = 12;
  // index past the register list, writes to it are dropped
  localparam logic [nrp_pkg::CfgIdxBits-1:0] RegUnused = 2'd3;

  // predictor copy of the configuration
  logic signed [3:0]  charge_z;
  logic signed [15:0] temp_q8;
  logic [16:0] log_frac [nrp_pkg::TabSize];

  nrp_pkg::nrp_out_t potential_q[$];
  int errors;
  int sent;
  bit stall_on;
  int ready_gap;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // log2 in q16 with table lookup and linear interpolation
  function automatic longint log2_q16(input logic [31:0] x);
    int p;
    logic [31:0] m;
    longint idx, rem, lo, hi;
    p = 31;
    while (p > 0 && x[p] == 1'b0) p--;
    m = x << (31 - p);
    idx = (m >> nrp_pkg::RemBits) & ((1 << nrp_pkg::LogTableBits) - 1);
    rem = m & ((1 << nrp_pkg::RemBits) - 1);
    lo = log_frac[idx];
    hi = log_frac[idx + 1];
    lo = lo + (((hi - lo) * rem) >> nrp_pkg::RemBits);
    return longint'(p) * 65536 + lo;
  endfunction

  // expected potential for one compartment
  function automatic nrp_pkg::nrp_out_t nernst_potential(input nrp_pkg::nrp_in_t c);
    nrp_pkg::nrp_out_t r;
    longint tk, l, zm, e;
    logic [63:0] a, lm, m, q;
    r = '0;
    if (c.recompute_reversal) begin
      r.reversal_written = 1'b1;
      if (charge_z == 0) e = 0;
      else if (c.conc_inside == 0) e = nrp_pkg::ErevLimitQ8;
      else if (c.conc_outside == 0) e = -longint'(nrp_pkg::ErevLimitQ8);
      else begin
        tk = longint'(temp_q8) + nrp_pkg::KelvinOffsetQ8;
        l = log2_q16(c.conc_outside) - log2_q16(c.conc_inside);
        a = (64'(tk) * 64'(nrp_pkg::KlnQ32) + 64'(1 << 23)) >> 24;
        lm = (l < 0) ? 64'(-l) : 64'(l);
        zm = (charge_z < 0) ? -longint'(charge_z) : longint'(charge_z);
        m = (a * lm + 64'(1 << 23)) >> 24;
        q = (m + 64'(zm / 2)) / 64'(zm);
        if (q > 64'(nrp_pkg::ErevLimitQ8)) q = 64'(nrp_pkg::ErevLimitQ8);
        e = ((l < 0) != (charge_z < 0)) ? -longint'(q) : longint'(q);
      end
      r.reversal_mv = e[28:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // mostly short gaps, sometimes long
  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(5, 30);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // valid stays high across back-to-back sends, drops only for a gap
  task automatic send_compartment(input nrp_pkg::nrp_in_t c);
    int g;
    g = stall_on ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    potential_q.push_back(nernst_potential(c));
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (potential_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [nrp_pkg::CfgIdxBits-1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == nrp_pkg::RegIonCharge) charge_z = val[3:0];
    else if (idx == nrp_pkg::RegTemperature) temp_q8 = val;
    @(posedge clk);
  endtask

  function automatic nrp_pkg::nrp_in_t mk(input logic [31:0] ci, input logic [31:0] co,
                                          input bit f);
    nrp_pkg::nrp_in_t c;
    c.conc_inside = ci;
    c.conc_outside = co;
    c.recompute_reversal = f;
    return c;
  endfunction

  function automatic logic [31:0] rand_conc();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(1, 255);
      3: return 32'h1_0000 + $urandom_range(0, 32'hF_FFFF);
      default: return $urandom();
    endcase
  endfunction

  // result checker: each transaction against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (potential_q.size() == 0) begin
        report_mismatch("unexpected result", out_data.reversal_mv, 0);
      end else begin
        nrp_pkg::nrp_out_t w;
        w = potential_q.pop_front();
        if (out_data.reversal_mv !== w.reversal_mv)
          report_mismatch("reversal_mv", out_data.reversal_mv, w.reversal_mv);
        if (out_data.reversal_written !== w.reversal_written)
          report_mismatch("reversal_written", out_data.reversal_written, w.reversal_written);
      end
    end
  end

  // receiver back-pressure: stalls of random length, mostly short
  always @(posedge clk) begin
    if (rst || !stall_on) begin
      out_ready <= 1'b1;
      ready_gap <= 0;
    end else if (ready_gap > 0) begin
      out_ready <= 1'b0;
      ready_gap <= ready_gap - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      ready_gap <= gap_len();
    end else begin
      out_ready <= 1'b1;
    end
  end

  // directed: field extremes, zero concentrations and no-recompute under reset configuration
  task automatic test_directed();
    send_compartment(mk(32'h1_0000, 32'h2_0000, 1'b0));
    send_compartment(mk(32'h1_0000, 32'h2_0000, 1'b1));
    send_compartment(mk(32'h2_0000, 32'h1_0000, 1'b1));
    send_compartment(mk(32'd0, 32'h1_0000, 1'b1));
    send_compartment(mk(32'h1_0000, 32'd0, 1'b1));
    send_compartment(mk(32'd0, 32'd0, 1'b1));
    send_compartment(mk(32'd1, 32'hFFFF_FFFF, 1'b1));
    send_compartment(mk(32'hFFFF_FFFF, 32'd1, 1'b1));
    send_compartment(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    send_compartment(mk(32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
    send_compartment(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
    wait_drained();
  endtask

  // sweep charge and temperature including out-of-range and zero charge
  task automatic test_config_sweep();
    logic [3:0] zs [7] = '{4'd0, 4'd4, 4'hC, 4'd7, 4'h8, 4'd3, 4'hF};
    logic [15:0] ts [4] = '{16'h8000, 16'h7FFF, 16'hCE00, 16'd25600};
    foreach (zs[i]) begin
      write_reg(nrp_pkg::RegIonCharge, {12'h0, zs[i]});
      write_reg(nrp_pkg::RegTemperature, ts[i % 4]);
      write_reg(RegUnused, 16'hFFFF);
      send_compartment(mk(32'd1, 32'hFFFF_FFFF, 1'b1));
      send_compartment(mk(32'd0, 32'd5, 1'b1));
      send_compartment(mk(32'd5, 32'd0, 1'b1));
      wait_drained();
    end
  endtask

  // random compartments in phases with fresh settings; one phase without idling
  task automatic test_random();
    for (int ph = 0; ph < 6; ph++) begin
      stall_on = (ph != 2);
      write_reg(nrp_pkg::RegIonCharge, 16'($urandom()));
      write_reg(nrp_pkg::RegTemperature, 16'($urandom()));
      for (int k = 0; k < 95; k++)
        send_compartment(mk(rand_conc(), rand_conc(), $urandom_range(0, 7) != 0));
      wait_drained();
    end
    write_reg(nrp_pkg::RegIonCharge, 16'd1);
    write_reg(nrp_pkg::RegTemperature, 16'd1613);
  endtask

  initial begin
    errors = 0;
    sent = 0;
    stall_on = 1'b1;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (int i = 0; i < nrp_pkg::TabSize; i++) log_frac[i] = nrp_pkg::log_entry(i);
    charge_z = 4'sd1;
    temp_q8 = 16'sd1613;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_random();
    wait_drained();
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // watchdog
  initial begin
    #10000000;
    $display("status: fail");
    $finish;
  end

endmodule

[files.f]
hdl/nrp_pkg.sv
hdl/nernst_reversal_potential.sv
tb/tb_nernst_reversal_potential.sv
